@@ hw/rtl/rexalu_pkg.sv @@
`timescale 1ns / 1ps

package rexalu_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned REG_W   = 5;
   localparam int unsigned IMM_W   = 16;
   localparam int unsigned CODE_W  = 6;
   localparam int unsigned LUI_SHIFT = 16;

   // Opcodes that select the register-register format
   localparam logic [CODE_W-1:0] OPC_RTYPE0 = 6'd0;
   localparam logic [CODE_W-1:0] OPC_RTYPE1 = 6'd1;

   // Register-register function codes
   localparam logic [CODE_W-1:0] FN_ADD  = 6'd16;
   localparam logic [CODE_W-1:0] FN_SUB  = 6'd18;
   localparam logic [CODE_W-1:0] FN_AND  = 6'd20;
   localparam logic [CODE_W-1:0] FN_OR   = 6'd21;
   localparam logic [CODE_W-1:0] FN_XOR  = 6'd22;
   localparam logic [CODE_W-1:0] FN_SLT  = 6'd24;
   localparam logic [CODE_W-1:0] FN_SLTU = 6'd25;
   localparam logic [CODE_W-1:0] FN_SLL  = 6'd37;
   localparam logic [CODE_W-1:0] FN_SRL  = 6'd38;
   localparam logic [CODE_W-1:0] FN_SRA  = 6'd39;
   localparam logic [CODE_W-1:0] FN_SLLV = 6'd45;
   localparam logic [CODE_W-1:0] FN_SRLV = 6'd46;
   localparam logic [CODE_W-1:0] FN_SRAV = 6'd47;

   // Immediate-format opcodes
   localparam logic [CODE_W-1:0] OPC_ADDI = 6'd16;
   localparam logic [CODE_W-1:0] OPC_ANDI = 6'd20;
   localparam logic [CODE_W-1:0] OPC_ORI  = 6'd21;
   localparam logic [CODE_W-1:0] OPC_XORI = 6'd22;
   localparam logic [CODE_W-1:0] OPC_SLTI = 6'd24;
   localparam logic [CODE_W-1:0] OPC_LW   = 6'd35;
   localparam logic [CODE_W-1:0] OPC_LUI  = 6'd39;
   localparam logic [CODE_W-1:0] OPC_SW   = 6'd43;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_LOAD  = 2'd2,
      ACT_STORE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      OP_ADD,
      OP_SUB,
      OP_AND,
      OP_OR,
      OP_XOR,
      OP_SLT,
      OP_SLTU,
      OP_SLL,
      OP_SRL,
      OP_SRA,
      OP_LUI
   } alu_op_type;

   typedef enum logic [1:0] {
      BSEL_REG,
      BSEL_SEXT,
      BSEL_ZEXT
   } bsel_type;

   // Decoded control for one word
   typedef struct packed {
      alu_op_type        op;
      bsel_type          bsel;
      logic              var_shift;
      logic              ok;
      logic [REG_W-1:0]  dest;
      action_type        act;
   } ctrl_type;

endpackage

@@ hw/rtl/rexalu_decode.sv @@
`timescale 1ns / 1ps

module rexalu_decode (
   input  logic                               valid_instruction,
   input  logic [rexalu_pkg::CODE_W-1:0]      opcode,
   input  logic [rexalu_pkg::CODE_W-1:0]      funct,
   input  logic [rexalu_pkg::REG_W-1:0]       dest_rd,
   input  logic [rexalu_pkg::REG_W-1:0]       dest_rt,
   output rexalu_pkg::ctrl_type               ctrl
);

   rexalu_pkg::alu_op_type   op;
   rexalu_pkg::bsel_type     bsel;
   rexalu_pkg::action_type   act;
   logic                     var_shift;
   logic                     ok;
   logic                     rtype;
   logic [rexalu_pkg::REG_W-1:0] dest;

   assign rtype = (opcode == rexalu_pkg::OPC_RTYPE0) || (opcode == rexalu_pkg::OPC_RTYPE1);

   // Map opcode and function code to an operation
   always_comb begin
      op        = rexalu_pkg::OP_ADD;
      bsel      = rexalu_pkg::BSEL_REG;
      act       = rexalu_pkg::ACT_WRITE;
      var_shift = 1'b0;
      ok        = 1'b1;
      if (rtype) begin
         unique case (funct)
            rexalu_pkg::FN_ADD:  op = rexalu_pkg::OP_ADD;
            rexalu_pkg::FN_SUB:  op = rexalu_pkg::OP_SUB;
            rexalu_pkg::FN_AND:  op = rexalu_pkg::OP_AND;
            rexalu_pkg::FN_OR:   op = rexalu_pkg::OP_OR;
            rexalu_pkg::FN_XOR:  op = rexalu_pkg::OP_XOR;
            rexalu_pkg::FN_SLT:  op = rexalu_pkg::OP_SLT;
            rexalu_pkg::FN_SLTU: op = rexalu_pkg::OP_SLTU;
            rexalu_pkg::FN_SLL:  op = rexalu_pkg::OP_SLL;
            rexalu_pkg::FN_SRL:  op = rexalu_pkg::OP_SRL;
            rexalu_pkg::FN_SRA:  op = rexalu_pkg::OP_SRA;
            rexalu_pkg::FN_SLLV: begin
               op        = rexalu_pkg::OP_SLL;
               var_shift = 1'b1;
            end
            rexalu_pkg::FN_SRLV: begin
               op        = rexalu_pkg::OP_SRL;
               var_shift = 1'b1;
            end
            rexalu_pkg::FN_SRAV: begin
               op        = rexalu_pkg::OP_SRA;
               var_shift = 1'b1;
            end
            default: ok = 1'b0;
         endcase
      end else begin
         unique case (opcode)
            rexalu_pkg::OPC_ADDI: begin
               op   = rexalu_pkg::OP_ADD;
               bsel = rexalu_pkg::BSEL_SEXT;
            end
            rexalu_pkg::OPC_ANDI: begin
               op   = rexalu_pkg::OP_AND;
               bsel = rexalu_pkg::BSEL_ZEXT;
            end
            rexalu_pkg::OPC_ORI: begin
               op   = rexalu_pkg::OP_OR;
               bsel = rexalu_pkg::BSEL_ZEXT;
            end
            rexalu_pkg::OPC_XORI: begin
               op   = rexalu_pkg::OP_XOR;
               bsel = rexalu_pkg::BSEL_ZEXT;
            end
            rexalu_pkg::OPC_SLTI: begin
               op   = rexalu_pkg::OP_SLT;
               bsel = rexalu_pkg::BSEL_SEXT;
            end
            rexalu_pkg::OPC_LW: begin
               op   = rexalu_pkg::OP_ADD;
               bsel = rexalu_pkg::BSEL_SEXT;
               act  = rexalu_pkg::ACT_LOAD;
            end
            rexalu_pkg::OPC_LUI: op = rexalu_pkg::OP_LUI;
            rexalu_pkg::OPC_SW: begin
               op   = rexalu_pkg::OP_ADD;
               bsel = rexalu_pkg::BSEL_SEXT;
               act  = rexalu_pkg::ACT_STORE;
            end
            default: ok = 1'b0;
         endcase
      end
      if (!valid_instruction) begin
         ok = 1'b0;
      end
   end

   // Pick destination; drop unknown words and writes to register zero
   always_comb begin
      dest = rtype ? dest_rd : dest_rt;
      ctrl.op        = op;
      ctrl.bsel      = bsel;
      ctrl.var_shift = var_shift;
      ctrl.ok        = ok;
      ctrl.dest      = ok ? dest : '0;
      priority if (!ok) begin
         ctrl.act = rexalu_pkg::ACT_NONE;
      end else if ((dest == '0) && (act != rexalu_pkg::ACT_STORE)) begin
         ctrl.act = rexalu_pkg::ACT_NONE;
      end else begin
         ctrl.act = act;
      end
   end

endmodule

@@ hw/rtl/rexalu_execute.sv @@
`timescale 1ns / 1ps

module rexalu_execute (
   input  rexalu_pkg::ctrl_type                ctrl,
   input  logic [rexalu_pkg::DATA_W-1:0]       operand_a,
   input  logic [rexalu_pkg::DATA_W-1:0]       operand_b,
   input  logic [rexalu_pkg::IMM_W-1:0]        immediate,
   input  logic [rexalu_pkg::REG_W-1:0]        shift_amount,
   output logic [rexalu_pkg::DATA_W-1:0]       result
);

   logic [rexalu_pkg::DATA_W-1:0] opb;
   logic [rexalu_pkg::DATA_W-1:0] value;
   logic [rexalu_pkg::REG_W-1:0]  shamt;

   // Select second operand
   always_comb begin
      unique case (ctrl.bsel)
         rexalu_pkg::BSEL_SEXT: opb = {{(rexalu_pkg::DATA_W-rexalu_pkg::IMM_W){immediate[rexalu_pkg::IMM_W-1]}}, immediate};
         rexalu_pkg::BSEL_ZEXT: opb = {{(rexalu_pkg::DATA_W-rexalu_pkg::IMM_W){1'b0}}, immediate};
         default:               opb = operand_b;
      endcase
   end

   assign shamt = ctrl.var_shift ? operand_a[rexalu_pkg::REG_W-1:0] : shift_amount;

   // Compute the value; shifts always act on rt
   always_comb begin
      unique case (ctrl.op)
         rexalu_pkg::OP_ADD:  value = operand_a + opb;
         rexalu_pkg::OP_SUB:  value = operand_a - opb;
         rexalu_pkg::OP_AND:  value = operand_a & opb;
         rexalu_pkg::OP_OR:   value = operand_a | opb;
         rexalu_pkg::OP_XOR:  value = operand_a ^ opb;
         rexalu_pkg::OP_SLT:  value = {{(rexalu_pkg::DATA_W-1){1'b0}},
                                       ($signed(operand_a) < $signed(opb))};
         rexalu_pkg::OP_SLTU: value = {{(rexalu_pkg::DATA_W-1){1'b0}}, (operand_a < opb)};
         rexalu_pkg::OP_SLL:  value = operand_b << shamt;
         rexalu_pkg::OP_SRL:  value = operand_b >> shamt;
         rexalu_pkg::OP_SRA:  value = $unsigned($signed(operand_b) >>> shamt);
         rexalu_pkg::OP_LUI:  value = rexalu_pkg::DATA_W'({{(rexalu_pkg::DATA_W-rexalu_pkg::IMM_W){1'b0}},
                                       immediate} << rexalu_pkg::LUI_SHIFT);
         default:             value = '0;
      endcase
   end

   // Zero the value for bubbles and unknown codes
   assign result = ctrl.ok ? value : '0;

endmodule

@@ hw/rtl/risc_execute_alu.sv @@
`timescale 1ns / 1ps

// A word accepted from req_ goes into the input register, then through decode and ALU into
// the result register, from which it is offered on rsp_. Throughput: one word per cycle
// while rsp_stall is low; decode and ALU sit in one pass between the two registers.
// Reset (synchronous, active high) empties both register stages; no word is pending after.
module risc_execute_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_valid_instruction,
   input  logic [rexalu_pkg::CODE_W-1:0]       req_opcode,
   input  logic [rexalu_pkg::CODE_W-1:0]       req_funct,
   input  logic [rexalu_pkg::REG_W-1:0]        req_shift_amount,
   input  logic [rexalu_pkg::REG_W-1:0]        req_dest_rd,
   input  logic [rexalu_pkg::REG_W-1:0]        req_dest_rt,
   input  logic [rexalu_pkg::DATA_W-1:0]       req_operand_a,
   input  logic [rexalu_pkg::DATA_W-1:0]       req_operand_b,
   input  logic [rexalu_pkg::IMM_W-1:0]        req_immediate,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rexalu_pkg::DATA_W-1:0]       rsp_result,
   output logic [rexalu_pkg::REG_W-1:0]        rsp_destination,
   output logic [1:0]                          rsp_action,
   output logic                                rsp_recognized
);

   logic                              in_valid_ff, in_valid_in;
   logic                              vi_ff;
   logic [rexalu_pkg::CODE_W-1:0]     opcode_ff;
   logic [rexalu_pkg::CODE_W-1:0]     funct_ff;
   logic [rexalu_pkg::REG_W-1:0]      shamt_ff;
   logic [rexalu_pkg::REG_W-1:0]      rd_ff;
   logic [rexalu_pkg::REG_W-1:0]      rt_ff;
   logic [rexalu_pkg::DATA_W-1:0]     a_ff;
   logic [rexalu_pkg::DATA_W-1:0]     b_ff;
   logic [rexalu_pkg::IMM_W-1:0]      imm_ff;

   logic                              out_valid_ff, out_valid_in;
   logic [rexalu_pkg::DATA_W-1:0]     result_ff, result_in;
   logic [rexalu_pkg::REG_W-1:0]      dest_ff;
   rexalu_pkg::action_type            act_ff;
   logic                              ok_ff;

   rexalu_pkg::ctrl_type              ctrl;
   logic                              req_take;
   logic                              out_take;

   // Result register frees when empty or when its word leaves
   assign out_take  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_take;
   assign req_take  = req_valid && !req_stall;

   // Input register
   assign in_valid_in = req_take || (in_valid_ff && !out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         vi_ff     <= req_valid_instruction;
         opcode_ff <= req_opcode;
         funct_ff  <= req_funct;
         shamt_ff  <= req_shift_amount;
         rd_ff     <= req_dest_rd;
         rt_ff     <= req_dest_rt;
         a_ff      <= req_operand_a;
         b_ff      <= req_operand_b;
         imm_ff    <= req_immediate;
      end
   end

   rexalu_decode u_decode (
      .valid_instruction (vi_ff),
      .opcode            (opcode_ff),
      .funct             (funct_ff),
      .dest_rd           (rd_ff),
      .dest_rt           (rt_ff),
      .ctrl              (ctrl)
   );

   rexalu_execute u_execute (
      .ctrl         (ctrl),
      .operand_a    (a_ff),
      .operand_b    (b_ff),
      .immediate    (imm_ff),
      .shift_amount (shamt_ff),
      .result       (result_in)
   );

   // Result register
   assign out_valid_in = out_take ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && in_valid_ff) begin
         result_ff <= result_in;
         dest_ff   <= ctrl.dest;
         act_ff    <= ctrl.act;
         ok_ff     <= ctrl.ok;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result      = result_ff;
   assign rsp_destination = dest_ff;
   assign rsp_action      = act_ff;
   assign rsp_recognized  = ok_ff;

endmodule

@@ hw/rtl/rexalu_checker.sv @@
`timescale 1ns / 1ps

module rexalu_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [rexalu_pkg::DATA_W-1:0]       rsp_result,
   input  logic [rexalu_pkg::REG_W-1:0]        rsp_destination,
   input  logic [1:0]                          rsp_action,
   input  logic                                rsp_recognized
);

   // An unrecognized word carries nothing
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_recognized |->
         (rsp_result == '0) && (rsp_destination == '0) &&
         (rsp_action == rexalu_pkg::ACT_NONE))
      else $error("unrecognized word has nonzero payload");

   // Register zero is never written or loaded
   a_reg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_destination == '0) |->
         (rsp_action == rexalu_pkg::ACT_NONE) || (rsp_action == rexalu_pkg::ACT_STORE))
      else $error("action aimed at register zero");

   // An empty result side never holds off the request side
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while result register is empty");

   // Reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("word pending after reset");

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result) &&
         $stable(rsp_destination) && $stable(rsp_action))
      else $error("stalled result word changed");

endmodule

bind risc_execute_alu rexalu_checker u_rexalu_checker (.*);
